// ----- src/lbsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lbsh_pkg
// Shared types and constants for the longest balanced span hash block.
// ----------------------------------------------------------------------------
package lbsh_pkg;

  localparam int unsigned FeatW  = 30;
  localparam int unsigned LenW   = 17;
  localparam int unsigned CfgW   = 5;
  localparam int unsigned HashW  = 32;
  localparam int unsigned EpochW = 8;
  // slot index is the low hash bits, so the depth stays a power of two
  localparam int unsigned TableEntries = 262144;
  localparam logic [HashW-1:0] HashMult = 32'd1000000007;
  localparam logic [CfgW-1:0]  NumFeatReset = 5'd30;

  typedef struct packed {
    logic [FeatW-1:0] features;
    logic             first;
  } in_t;

  typedef struct packed {
    logic [LenW-1:0] best_length;
    logic            table_full;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic clr_done;
    logic start_seq;
    logic seed;
    logic step;
    logic hash_step;
    logic probe_init;
    logic rd;
    logic adv;
    logic ins;
    logic upd;
    logic out;
    logic out_full;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic epoch_wrap;
    logic full;
    logic kzero;
    logic hash_last;
    logic clr_last;
    logic hit_empty;
    logic hit_match;
    logic tries_last;
  } sts_t;

endpackage

// ----- src/lbsh_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbsh_ctrl
// Sequencer: clearing pass, sequence start, hashing loop and table probe.
// ----------------------------------------------------------------------------
module lbsh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lbsh_pkg::sts_t sts_i,
  output lbsh_pkg::cmd_t cmd_o
);
  import lbsh_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_SEED  = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_HASH  = 4'd5;
  localparam logic [3:0] S_PINIT = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       pend_q, pend_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.clr_done = 1'b1;
          pend_d  = 1'b0;
          state_d = pend_q ? S_SEED : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.first) begin
          cmd_o.start_seq = 1'b1;
          if (sts_i.epoch_wrap) begin
            pend_d  = 1'b1;
            state_d = S_CLEAR;
          end else begin
            state_d = S_SEED;
          end
        end else begin
          state_d = S_EVAL;
        end
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.full) begin
          cmd_o.out      = 1'b1;
          cmd_o.out_full = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.kzero) begin
          state_d = S_PINIT;
        end else begin
          cmd_o.hash_step = 1'b1;
          if (sts_i.hash_last) state_d = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (sts_i.hit_empty) begin
          cmd_o.ins = 1'b1;
          state_d   = S_OUT;
        end else if (sts_i.hit_match) begin
          cmd_o.upd = 1'b1;
          state_d   = S_OUT;
        end else if (sts_i.tries_last) begin
          state_d = S_OUT;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_OUT: begin
        cmd_o.out = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ($past(state_q) == S_RD))
    else $error("compare without a preceding read");
  a_ins_upd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ins && cmd_o.upd))
    else $error("insert and update together");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_out_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out |=> !cmd_o.out)
    else $error("two results for one word");

endmodule

// ----- src/lbsh_dp.sv -----
// ----------------------------------------------------------------------------
// lbsh_dp
// Datapath: feature counters, Horner hash unit, epoch-tagged probe table.
// ----------------------------------------------------------------------------
module lbsh_dp #(
  parameter int unsigned MAX_FEATURES  = 30,
  parameter int unsigned MAX_ITEMS     = 131071
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbsh_pkg::in_t        item_i,
  input  logic [4:0]           num_features_i,
  input  lbsh_pkg::cmd_t       cmd_i,
  output lbsh_pkg::sts_t       sts_o,
  output lbsh_pkg::out_t       result_o,
  output logic                 done_o
);
  import lbsh_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW   = $clog2(TableEntries);
  localparam int unsigned JW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned EW   = EpochW + HashW + PW;
  localparam logic [PW-1:0] MaxPos = PW'(MAX_ITEMS);
  localparam logic [CfgW-1:0] MaxK = CfgW'(MAX_FEATURES);

  logic [FeatW-1:0]  feat_q;
  logic              first_q;
  logic [PW-1:0]     cnt_q [MAX_FEATURES];
  logic [PW-1:0]     pos_q;
  logic [PW-1:0]     best_q;
  logic [EpochW-1:0] epoch_q;
  logic [HashW-1:0]  h_q;
  logic [JW-1:0]     j_q;
  logic [IW-1:0]     slot_q, tries_q, clr_q;
  logic [EW-1:0]     mem [TableEntries];
  logic [EW-1:0]     rdata_q;
  out_t              res_q;
  logic              done_q;

  logic [CfgW-1:0]   kf;
  logic [HashW-1:0]  diff;
  logic [HashW-1:0]  prod;
  logic [EpochW-1:0] r_epoch;
  logic [HashW-1:0]  r_hash;
  logic [PW-1:0]     r_pos;
  logic [PW-1:0]     span;
  logic              we;
  logic [IW-1:0]     addr;
  logic [EW-1:0]     wdata;

  assign kf     = (num_features_i > MaxK) ? MaxK : num_features_i;
  assign diff   = HashW'(cnt_q[j_q]) - HashW'(cnt_q[0]);
  assign prod   = h_q * HashMult;
  assign r_epoch = rdata_q[EW-1 -: EpochW];
  assign r_hash  = rdata_q[PW +: HashW];
  assign r_pos   = rdata_q[PW-1:0];
  assign span    = pos_q - r_pos;

  assign sts_o.first      = first_q;
  assign sts_o.epoch_wrap = (epoch_q == '1);
  assign sts_o.full       = (pos_q >= MaxPos);
  assign sts_o.kzero      = (kf == '0);
  assign sts_o.hash_last  = (CfgW'(j_q) == kf - CfgW'(1));
  assign sts_o.clr_last   = (clr_q == '1);
  assign sts_o.hit_empty  = (r_epoch != epoch_q);
  assign sts_o.hit_match  = (r_hash == h_q);
  assign sts_o.tries_last = (tries_q == '1);

  always_comb begin
    we    = cmd_i.clr_wr | cmd_i.seed | cmd_i.ins;
    addr  = slot_q;
    wdata = {epoch_q, h_q, pos_q};
    if (cmd_i.clr_wr) begin
      addr  = clr_q;
      wdata = '0;
    end else if (cmd_i.seed) begin
      addr  = '0;
      wdata = {epoch_q, {HashW{1'b0}}, {PW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    if (cmd_i.rd) rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      feat_q  <= item_i.features;
      first_q <= item_i.first;
    end
    if (cmd_i.step) begin
      h_q <= '0;
      j_q <= '0;
    end else if (cmd_i.hash_step) begin
      h_q <= prod + diff;
      j_q <= j_q + JW'(1);
    end
    if (cmd_i.probe_init) begin
      slot_q  <= h_q[IW-1:0];
      tries_q <= '0;
    end else if (cmd_i.adv) begin
      slot_q  <= slot_q + IW'(1);
      tries_q <= tries_q + IW'(1);
    end
    if (cmd_i.out) begin
      res_q.best_length <= LenW'(best_q);
      res_q.table_full  <= cmd_i.out_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FEATURES; i++) cnt_q[i] <= '0;
      pos_q   <= '0;
      best_q  <= '0;
      epoch_q <= EpochW'(1);
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.out;
      if (cmd_i.clr_wr) clr_q <= clr_q + IW'(1);
      if (cmd_i.clr_done) epoch_q <= EpochW'(1);
      if (cmd_i.start_seq) begin
        for (int i = 0; i < MAX_FEATURES; i++) cnt_q[i] <= '0;
        pos_q   <= '0;
        best_q  <= '0;
        epoch_q <= epoch_q + EpochW'(1);
      end
      if (cmd_i.step) begin
        pos_q <= pos_q + PW'(1);
        for (int i = 0; i < MAX_FEATURES; i++) begin
          if (CfgW'(i) < kf) cnt_q[i] <= cnt_q[i] + PW'(feat_q[i]);
        end
      end
      if (cmd_i.upd && (span > best_q)) best_q <= span;
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

// ----- src/longest_balanced_span_hash.sv -----
// ----------------------------------------------------------------------------
// longest_balanced_span_hash
// Longest balanced span over feature words via hashed count differences.
// ----------------------------------------------------------------------------
//  port group            dir  handshake
//  item_i                in   start / busy
//  result_o              out  done_o strobe, one cycle
//  cfg_wdata_i           in   cfg_we_i, no wait
//
//  Each word is loaded and checked, hashed by the Horner multiply-add unit over
//  the k active features, then probed in the single-port table, a read and a
//  compare per slot visited; a first word adds a seed write, and a word past the
//  item limit skips hashing and probing. After reset, and on every 255th first
//  word, a clearing pass over all TableEntries slots holds busy high.
//  The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module longest_balanced_span_hash #(
  parameter int unsigned MAX_FEATURES  = 30,
  parameter int unsigned MAX_ITEMS     = 131071
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lbsh_pkg::in_t        item_i,
  output lbsh_pkg::out_t       result_o,
  output logic                 done_o,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i
);
  import lbsh_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [CfgW-1:0] num_features_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_features_q <= NumFeatReset;
    end else if (cfg_we_i) begin
      num_features_q <= cfg_wdata_i;
    end
  end

  lbsh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lbsh_dp #(
    .MAX_FEATURES  (MAX_FEATURES),
    .MAX_ITEMS     (MAX_ITEMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .num_features_i (num_features_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .done_o         (done_o)
  );

endmodule
